// File: sv/bdr_pkg.sv
// Package for the box downsampler: sizes, derived widths and the structs
// that pass between the top level, the position tracker and the channel lanes.
// Depends on nothing.
package bdr_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_SCALE = 8;
	localparam int LANES     = 4;

	localparam int CH_W    = 16;
	localparam int SUM_W   = 22;
	localparam int SCALE_W = 4;
	localparam int WIDTH_W = 11;

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int SC_W   = $clog2(MAX_WIDTH * MAX_SCALE);
	localparam int SUB_W  = $clog2(MAX_SCALE);
	localparam int AREA_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
	localparam int SHIFT_W = $clog2(SUM_W);
	localparam int RCNT_W = $clog2(SC_W + 1);

	// Accumulator division retires this many quotient bits per cycle.
	localparam int DIV_BITS = 2;
	localparam int DIV_CYC  = SUM_W / DIV_BITS;
	localparam int DCNT_W   = $clog2(DIV_CYC + 1);

	// Configuration register indexes, taken from address bit 2.
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] col;
		logic              first;
		logic              last;
		logic              row_end;
	} pos_t;

	typedef struct packed {
		logic                rd;
		logic [ADDR_W-1:0]   addr;
		logic                upd;
		logic                first;
		logic                last;
		logic                pow2;
		logic [SHIFT_W-1:0]  shift;
		logic [AREA_W-1:0]   area;
		logic                step;
	} lane_cmd_t;

endpackage

// File: sv/bdr_if.sv
// Stream interfaces of the box downsampler: source pixels and averaged pixels.
// Depends on nothing.
interface bdr_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] red_in;
	logic [15:0] green_in;
	logic [15:0] blue_in;
	logic [15:0] alpha_in;
	logic        frame_start;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, frame_start,
		input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, frame_start,
		output ready);
endinterface

interface bdr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] red_out;
	logic [15:0] green_out;
	logic [15:0] blue_out;
	logic [15:0] alpha_out;
	logic        row_end;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, row_end,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, row_end,
		output ready);
endinterface

// File: sv/box_downsample_rgba.sv
// Top level of the RGBA box downsampler: configuration registers, sequencer,
// four channel lanes and the output register. Depends on bdr_pkg, bdr_if,
// bdr_pos and bdr_lane.
//
//   Port     Kind        Width  Carries
//   src      stream in   65     source pixel, RGBA 16 bits each, frame_start
//   dst      stream out  65     averaged pixel, RGBA 16 bits each, row_end
//   apb      config      32     scale at 0x0, out_width at 0x4
//
// For a source pixel, the transfer cycle reads the column sums of all four
// lanes and the next cycle writes the updated sums back. A pixel that closes
// a block is then averaged with a shift when scale is 1, 2, 4 or 8, or by
// the radix-4 divider in each lane otherwise.
// After a write to scale, the column position is remapped by a bit-serial
// divider, during which no source pixel is taken.
// Reset is asynchronous and active low; the accumulator memories hold no reset
// value. A finished pixel waits in the output register while the next source
// pixels are taken; only a second block result stalls behind a stalled sink.
module box_downsample_rgba (
	input  logic        clk,
	input  logic        arst_n,
	bdr_in_if.sink      src,
	bdr_out_if.source   dst,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [bdr_pkg::SCALE_W-1:0]    scale_q;
	logic [bdr_pkg::WIDTH_W-1:0]    width_q;
	logic                           resync_q;
	logic [bdr_pkg::DCNT_W-1:0]     cnt_q;
	logic                           first_s1;
	logic                           last_s1;
	logic                           row_end_s1;
	logic                           out_valid_q;
	logic [bdr_pkg::CH_W-1:0]       out_q [bdr_pkg::LANES];
	logic                           row_end_q;

	logic                           wr_en;
	logic [bdr_pkg::SCALE_W-1:0]    s_eff;
	logic [bdr_pkg::WIDTH_W-1:0]    w_eff;
	logic                           pow2;
	logic [bdr_pkg::SHIFT_W-1:0]    shift;
	logic [2*bdr_pkg::SCALE_W-1:0]  area_full;
	logic                           accept;
	logic                           load_out;
	logic                           pos_busy;
	bdr_pkg::pos_t                  pos;
	bdr_pkg::lane_cmd_t             cmd;
	logic [bdr_pkg::CH_W-1:0]       pix [bdr_pkg::LANES];
	logic [bdr_pkg::CH_W-1:0]       avg [bdr_pkg::LANES];

	// Configuration port. The register index is address bit 2; writes complete
	// in the access cycle since pready is tied high.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[2])
			bdr_pkg::REG_SCALE: prdata = 32'(scale_q);
			bdr_pkg::REG_WIDTH: prdata = 32'(width_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= bdr_pkg::SCALE_W'(1);
			width_q  <= bdr_pkg::WIDTH_W'(bdr_pkg::MAX_WIDTH);
			resync_q <= 1'b0;
		end else begin
			resync_q <= 1'b0;
			if (wr_en) begin
				unique case (paddr[2])
					bdr_pkg::REG_SCALE: begin
						scale_q  <= pwdata[bdr_pkg::SCALE_W-1:0];
						resync_q <= 1'b1;
					end
					bdr_pkg::REG_WIDTH: width_q <= pwdata[bdr_pkg::WIDTH_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Out-of-range settings are clamped into the supported range.
	always_comb begin
		if (scale_q == '0)
			s_eff = bdr_pkg::SCALE_W'(1);
		else if (scale_q > bdr_pkg::SCALE_W'(bdr_pkg::MAX_SCALE))
			s_eff = bdr_pkg::SCALE_W'(bdr_pkg::MAX_SCALE);
		else
			s_eff = scale_q;
		if (width_q == '0)
			w_eff = bdr_pkg::WIDTH_W'(1);
		else if (width_q > bdr_pkg::WIDTH_W'(bdr_pkg::MAX_WIDTH))
			w_eff = bdr_pkg::WIDTH_W'(bdr_pkg::MAX_WIDTH);
		else
			w_eff = width_q;
	end

	// Block area; power-of-two areas are averaged with a shift.
	assign area_full = s_eff * s_eff;
	assign pow2      = (s_eff & (s_eff - 1'b1)) == '0;
	always_comb begin
		shift = '0;
		for (int i = 0; i < bdr_pkg::SCALE_W; i++) begin
			if (s_eff[i])
				shift = bdr_pkg::SHIFT_W'(2 * i);
		end
	end

	bdr_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.scale       (s_eff),
		.width       (w_eff),
		.adv         (accept),
		.frame_start (src.frame_start),
		.resync      (resync_q),
		.pos         (pos),
		.busy        (pos_busy)
	);

	assign src.ready = (state_q == ST_IDLE) && !pos_busy && !resync_q;
	assign accept    = src.valid && src.ready;

	always_comb begin
		cmd.rd    = accept;
		cmd.addr  = pos.col;
		cmd.upd   = state_q == ST_UPD;
		cmd.first = first_s1;
		cmd.last  = last_s1;
		cmd.pow2  = pow2;
		cmd.shift = shift;
		cmd.area  = area_full[bdr_pkg::AREA_W-1:0];
		cmd.step  = state_q == ST_DIV;
	end

	assign pix[0] = src.red_in;
	assign pix[1] = src.green_in;
	assign pix[2] = src.blue_in;
	assign pix[3] = src.alpha_in;

	for (genvar g = 0; g < bdr_pkg::LANES; g++) begin : g_lane
		bdr_lane u_lane (
			.clk (clk),
			.pix (pix[g]),
			.cmd (cmd),
			.avg (avg[g])
		);
	end

	// Sequencer: one source pixel at a time, then, if the pixel closed a block,
	// divide (skipped for a power-of-two scale) and deliver.
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || dst.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			first_s1   <= 1'b0;
			last_s1    <= 1'b0;
			row_end_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_s1   <= pos.first;
						last_s1    <= pos.last;
						row_end_s1 <= pos.row_end;
						state_q    <= ST_UPD;
					end
				end
				ST_UPD: begin
					cnt_q <= '0;
					if (!last_s1)
						state_q <= ST_IDLE;
					else if (pow2)
						state_q <= ST_OUT;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bdr_pkg::DCNT_W'(bdr_pkg::DIV_CYC - 1))
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: the merged result of all lanes and the row flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (dst.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < bdr_pkg::LANES; i++)
				out_q[i] <= avg[i];
			row_end_q <= row_end_s1;
		end
	end

	assign dst.valid     = out_valid_q;
	assign dst.red_out   = out_q[0];
	assign dst.green_out = out_q[1];
	assign dst.blue_out  = out_q[2];
	assign dst.alpha_out = out_q[3];
	assign dst.row_end   = row_end_q;

endmodule

// File: sv/bdr_lane.sv
// One channel lane: column accumulator memory, saturating add and a radix-4
// restoring divider for the block average. Depends on bdr_pkg.
module bdr_lane (
	input  logic                   clk,
	input  logic [bdr_pkg::CH_W-1:0] pix,
	input  bdr_pkg::lane_cmd_t     cmd,
	output logic [bdr_pkg::CH_W-1:0] avg
);

	logic [bdr_pkg::SUM_W-1:0]  mem [bdr_pkg::MAX_WIDTH];
	logic [bdr_pkg::SUM_W-1:0]  rdata_s1;
	logic [bdr_pkg::CH_W-1:0]   pix_s1;
	logic [bdr_pkg::ADDR_W-1:0] addr_s1;
	logic [bdr_pkg::SUM_W-1:0]  nq_q;
	logic [bdr_pkg::AREA_W-1:0] rem_q;

	logic [bdr_pkg::SUM_W:0]    sum_wide;
	logic [bdr_pkg::SUM_W-1:0]  sum_new;
	logic [bdr_pkg::SUM_W-1:0]  nq_n;
	logic [bdr_pkg::AREA_W-1:0] rem_n;
	logic [bdr_pkg::AREA_W:0]   trial;

	// Sum saturates at full scale; the first pixel of a block starts it fresh.
	assign sum_wide = {1'b0, rdata_s1} + (bdr_pkg::SUM_W + 1)'(pix_s1);
	assign sum_new  = cmd.first ? bdr_pkg::SUM_W'(pix_s1) :
		(sum_wide[bdr_pkg::SUM_W] ? '1 : sum_wide[bdr_pkg::SUM_W-1:0]);

	// nq_q shifts the dividend out at the top and the quotient in at the bottom.
	always_comb begin
		rem_n = rem_q;
		nq_n  = nq_q;
		trial = '0;
		for (int i = 0; i < bdr_pkg::DIV_BITS; i++) begin
			trial = {rem_n, nq_n[bdr_pkg::SUM_W-1]};
			nq_n  = {nq_n[bdr_pkg::SUM_W-2:0], 1'b0};
			if (trial >= {1'b0, cmd.area}) begin
				trial   = trial - {1'b0, cmd.area};
				nq_n[0] = 1'b1;
			end
			rem_n = trial[bdr_pkg::AREA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rdata_s1 <= mem[cmd.addr];
			pix_s1   <= pix;
			addr_s1  <= cmd.addr;
		end
		if (cmd.upd) begin
			mem[addr_s1] <= sum_new;
			if (cmd.last) begin
				rem_q <= '0;
				nq_q  <= cmd.pow2 ? (sum_new >> cmd.shift) : sum_new;
			end
		end else if (cmd.step) begin
			rem_q <= rem_n;
			nq_q  <= nq_n;
		end
	end

	assign avg = (|nq_q[bdr_pkg::SUM_W-1:bdr_pkg::CH_W]) ? '1 : nq_q[bdr_pkg::CH_W-1:0];

endmodule

// File: sv/bdr_pos.sv
// Position tracker: source column, sub-column and row within the block row,
// plus a bit-serial divider that remaps the column after a scale change.
// Depends on bdr_pkg.
module bdr_pos (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bdr_pkg::SCALE_W-1:0] scale,
	input  logic [bdr_pkg::WIDTH_W-1:0] width,
	input  logic                        adv,
	input  logic                        frame_start,
	input  logic                        resync,
	output bdr_pkg::pos_t               pos,
	output logic                        busy
);

	logic [bdr_pkg::SC_W-1:0]   sc_q;
	logic [bdr_pkg::SC_W-1:0]   col_q;
	logic [bdr_pkg::SUB_W-1:0]  sub_q;
	logic [bdr_pkg::SUB_W-1:0]  row_q;
	logic                       busy_q;
	logic [bdr_pkg::RCNT_W-1:0] cnt_q;
	logic [bdr_pkg::SC_W-1:0]   dq_q;
	logic [bdr_pkg::SUB_W-1:0]  dr_q;

	logic [bdr_pkg::SC_W-1:0]   sc_c;
	logic [bdr_pkg::SC_W-1:0]   col_c;
	logic [bdr_pkg::SUB_W-1:0]  sub_c;
	logic [bdr_pkg::SUB_W-1:0]  row_c;
	logic                       sub_end;
	logic                       row_last;
	logic                       col_end;
	logic [bdr_pkg::SUB_W:0]    trial;
	logic                       qbit;
	logic [bdr_pkg::SUB_W-1:0]  dr_n;
	logic [bdr_pkg::SC_W-1:0]   dq_n;

	// Position of the pixel being taken, after frame start and stale checks.
	always_comb begin
		sc_c  = sc_q;
		col_c = col_q;
		sub_c = sub_q;
		row_c = row_q;
		if (frame_start) begin
			sc_c  = '0;
			col_c = '0;
			sub_c = '0;
			row_c = '0;
		end
		if (col_c >= bdr_pkg::SC_W'(width)) begin
			sc_c  = '0;
			col_c = '0;
			sub_c = '0;
		end
		if (bdr_pkg::SCALE_W'(row_c) >= scale) begin
			row_c = '0;
		end
	end

	assign sub_end  = bdr_pkg::SCALE_W'(sub_c) == scale - 1'b1;
	assign row_last = bdr_pkg::SCALE_W'(row_c) == scale - 1'b1;
	assign col_end  = col_c == bdr_pkg::SC_W'(width - 1'b1);

	assign pos.col     = col_c[bdr_pkg::ADDR_W-1:0];
	assign pos.first   = (row_c == '0) && (sub_c == '0);
	assign pos.last    = row_last && sub_end;
	assign pos.row_end = col_end;
	assign busy        = busy_q;

	// One quotient bit per cycle: source column divided by the new scale.
	assign trial = {dr_q, dq_q[bdr_pkg::SC_W-1]};
	assign qbit  = bdr_pkg::SCALE_W'(trial) >= scale;
	assign dr_n  = qbit ? bdr_pkg::SUB_W'(bdr_pkg::SCALE_W'(trial) - scale) :
		trial[bdr_pkg::SUB_W-1:0];
	assign dq_n  = {dq_q[bdr_pkg::SC_W-2:0], qbit};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			col_q  <= '0;
			sub_q  <= '0;
			row_q  <= '0;
			busy_q <= 1'b0;
			cnt_q  <= '0;
			dq_q   <= '0;
			dr_q   <= '0;
		end else if (resync) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			dq_q   <= sc_q;
			dr_q   <= '0;
		end else if (busy_q) begin
			dq_q  <= dq_n;
			dr_q  <= dr_n;
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == bdr_pkg::RCNT_W'(bdr_pkg::SC_W - 1)) begin
				busy_q <= 1'b0;
				col_q  <= dq_n;
				sub_q  <= dr_n;
			end
		end else if (adv) begin
			if (sub_end && col_end) begin
				sc_q  <= '0;
				col_q <= '0;
				sub_q <= '0;
				row_q <= row_last ? '0 : row_c + 1'b1;
			end else begin
				sc_q  <= sc_c + 1'b1;
				row_q <= row_c;
				if (sub_end) begin
					sub_q <= '0;
					col_q <= col_c + 1'b1;
				end else begin
					sub_q <= sub_c + 1'b1;
					col_q <= col_c;
				end
			end
		end
	end

endmodule
